/* hdl/lpe_pkg.sv */
// Shared types and constants of the line position estimator.
`default_nettype none

package lpe_pkg;

	localparam int DEF_MAX_SENSORS  = 8;
	localparam int DEF_READING_BITS = 12;

	localparam int DIV_W       = 32;
	localparam int DIV_STEP_W  = $clog2(DIV_W);
	localparam int SCALE_W     = 10;

	localparam logic [SCALE_W-1:0] SCALE_FULL   = 10'd1000;
	localparam logic [SCALE_W-1:0] SEEN_LIMIT   = 10'd200;
	localparam logic [SCALE_W-1:0] WEIGHT_LIMIT = 10'd50;

	typedef enum logic [1:0] {
		ACT_POS = 2'd0,
		ACT_CAL = 2'd1,
		ACT_CLR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_COUNT      = 2'd0,
		REG_FULL_SCALE = 2'd1,
		REG_CAL_ENABLE = 2'd2
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_CAL_RD,
		ST_CAL_WR,
		ST_APP_RD,
		ST_APP_WR,
		ST_POS_RD,
		ST_POS_SC,
		ST_POS_MUL,
		ST_DIV_SC,
		ST_POS_ACC,
		ST_POS_SUM,
		ST_POS_END,
		ST_DIV_POS,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

/* hdl/line_position_estimator_core.sv */
// Line position estimator: calibration tables, scaling, weighted-mean position.
//
// Each word is processed on its own. A position word runs the radix-2 divider when
// a calibrated reading is scaled, and runs it again for the weighted mean on the
// last word of a sweep in which a line was seen. A calibration word reads the burst
// table and updates it for a sensor in use; the last word of a burst then walks
// every table entry to fold the burst into the stored range, and a clear word, or
// the first calibration word after reset, walks the stored table. One divider serves
// both divisions. No clearing pass follows reset.
`default_nettype none

module line_position_estimator_core
	import lpe_pkg::*;
#(
	parameter int MAX_SENSORS  = DEF_MAX_SENSORS,
	parameter int READING_BITS = DEF_READING_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tdata: sensor[2:0], reading[14:3], zero[15]
	input  wire logic [15:0] s_axis_tdata,
	// tuser: action[1:0], first_item[2]
	input  wire logic [2:0]  s_axis_tuser,
	input  wire logic        s_axis_tlast,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: scaled_value[11:0], position[24:12], zero[31:25]
	output logic [31:0]      m_axis_tdata,
	// tuser: line_seen[0]
	output logic             m_axis_tuser,
	output logic             m_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int RB    = READING_BITS;
	localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int CNT_W = $clog2(MAX_SENSORS + 1);
	localparam int TOP_W = $clog2((MAX_SENSORS - 1) * 1000 + 1);
	localparam int VAL_W = (RB > SCALE_W) ? RB : SCALE_W;
	localparam int NUM_W = RB + SCALE_W;
	localparam int WGT_W = 13;
	localparam int MEM_W = 2 * RB;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SENSORS - 1);

	state_t state_q, state_nxt;

	// configuration
	logic [3:0]  cnt_q;
	logic [11:0] fs_q;
	logic        cen_q;

	// current word
	logic [1:0]    act_q;
	logic [2:0]    sensor_q;
	logic [RB-1:0] rd_q;
	logic          first_q;
	logic          last_q;

	// block state
	logic                   cal_q;
	logic                   seen_q;
	logic [DIV_W-1:0]       wsum_q;
	logic [DIV_W-1:0]       vsum_q;
	logic [12:0]            prev_q;
	logic [MAX_SENSORS-1:0] bvalid_q;
	logic [IDX_W-1:0]       idx_q;

	// datapath
	logic [RB-1:0]         diff_q;
	logic [15:0]           span_q;
	logic [VAL_W-1:0]      val_q;
	logic [DIV_W-1:0]      prod_q;
	logic [12:0]           pos_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      quo_q;
	logic [DIV_W-1:0]      dvs_q;
	logic [DIV_STEP_W-1:0] step_q;

	// output register
	logic        out_valid_q;
	logic [11:0] out_scaled_q;
	logic [12:0] out_pos_q;
	logic        out_last_q;
	logic        out_seen_q;

	// memories
	logic [MEM_W-1:0] stor_mem [MAX_SENSORS];
	logic [MEM_W-1:0] burst_mem [MAX_SENSORS];
	logic [MEM_W-1:0] stor_rd_q;
	logic [MEM_W-1:0] burst_rd_q;

	logic             stor_re, stor_we, burst_re, burst_we;
	logic [IDX_W-1:0] stor_raddr, stor_waddr, burst_raddr, burst_waddr;
	logic [MEM_W-1:0] stor_wdata, burst_wdata;

	// derived values
	logic [CNT_W-1:0] n_act;
	logic [TOP_W-1:0] top;
	logic             in_use;
	logic [IDX_W-1:0] sidx;
	logic [RB-1:0]    smax, smin, bmax, bmin;
	logic [RB-1:0]    new_max, new_min;
	logic [15:0]      span_c;
	logic             sc_go;
	logic [DIV_W:0]   div_tmp;
	logic             div_ge;
	logic [DIV_W-1:0] div_qn;
	logic [TOP_W-1:0] pos_cap;
	logic [TOP_W-1:0] pos_edge;
	logic             pos_go;
	logic             accept, emit;
	logic [WGT_W-1:0] wgt;
	logic [DIV_W:0]   wsum_add, vsum_add;

	always_comb begin
		if (cnt_q == 4'd0) begin
			n_act = CNT_W'(1);
		end else if (32'(cnt_q) > 32'(MAX_SENSORS)) begin
			n_act = CNT_W'(MAX_SENSORS);
		end else begin
			n_act = CNT_W'(cnt_q);
		end
	end

	assign top      = TOP_W'((32'(n_act) - 32'd1) * 32'd1000);
	assign in_use   = 32'(sensor_q) < 32'(n_act);
	assign sidx     = IDX_W'(sensor_q);
	assign smax     = stor_rd_q[MEM_W-1:RB];
	assign smin     = stor_rd_q[RB-1:0];
	assign bmax     = burst_rd_q[MEM_W-1:RB];
	assign bmin     = burst_rd_q[RB-1:0];
	assign span_c   = 16'(16'(smax) - 16'(smin));
	assign sc_go    = cal_q && in_use && (span_c != 16'd0) && (rd_q > smin);
	assign div_tmp  = {rem_q, quo_q[DIV_W-1]};
	assign div_ge   = div_tmp >= {1'b0, dvs_q};
	assign div_qn   = {quo_q[DIV_W-2:0], div_ge};
	assign pos_cap  = (div_qn > DIV_W'(top)) ? top : TOP_W'(div_qn);
	assign pos_edge = (32'(prev_q) < 32'(top >> 1)) ? '0 : top;
	assign pos_go   = seen_q && (vsum_q != '0);
	assign wgt      = WGT_W'(32'(sensor_q) * 32'd1000);
	assign wsum_add = {1'b0, wsum_q} + {1'b0, prod_q};
	assign vsum_add = {1'b0, vsum_q} + (DIV_W + 1)'(val_q);

	always_comb begin
		if (bmin > smax) begin
			new_max = bmin;
		end else begin
			new_max = smax;
		end
		if (bmax < smin) begin
			new_min = bmax;
		end else begin
			new_min = smin;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (s_axis_tuser[1:0])
						ACT_POS: state_nxt = ST_POS_RD;
						ACT_CAL: begin
							if (!cen_q) begin
								state_nxt = ST_IDLE;
							end else if (cal_q) begin
								state_nxt = ST_CAL_RD;
							end else begin
								state_nxt = ST_CLR;
							end
						end
						ACT_CLR: state_nxt = ST_CLR;
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_CLR: begin
				if (idx_q == IDX_LAST) begin
					state_nxt = (act_q == ACT_CAL) ? ST_CAL_RD : ST_IDLE;
				end
			end
			ST_CAL_RD: begin
				if (in_use) begin
					state_nxt = ST_CAL_WR;
				end else begin
					state_nxt = last_q ? ST_APP_RD : ST_IDLE;
				end
			end
			ST_CAL_WR:  state_nxt = last_q ? ST_APP_RD : ST_IDLE;
			ST_APP_RD:  state_nxt = ST_APP_WR;
			ST_APP_WR:  state_nxt = (idx_q == IDX_LAST) ? ST_IDLE : ST_APP_RD;
			ST_POS_RD:  state_nxt = ST_POS_SC;
			ST_POS_SC:  state_nxt = sc_go ? ST_POS_MUL : ST_POS_ACC;
			ST_POS_MUL: state_nxt = ST_DIV_SC;
			ST_DIV_SC:  state_nxt = (step_q == '0) ? ST_POS_ACC : ST_DIV_SC;
			ST_POS_ACC: state_nxt = ST_POS_SUM;
			ST_POS_SUM: state_nxt = last_q ? ST_POS_END : ST_EMIT;
			ST_POS_END: state_nxt = pos_go ? ST_DIV_POS : ST_EMIT;
			ST_DIV_POS: state_nxt = (step_q == '0) ? ST_EMIT : ST_DIV_POS;
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		accept        = s_axis_tvalid && (state_q == ST_IDLE);
		emit          = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
		stor_re       = (state_q == ST_POS_RD) || (state_q == ST_APP_RD);
		stor_raddr    = (state_q == ST_APP_RD) ? idx_q : sidx;
		stor_we       = (state_q == ST_CLR) || ((state_q == ST_APP_WR) && bvalid_q[idx_q]);
		stor_waddr    = idx_q;
		stor_wdata    = (state_q == ST_CLR) ? {RB'(0), RB'(fs_q)} : {new_max, new_min};
		burst_re      = (state_q == ST_CAL_RD) || (state_q == ST_APP_RD);
		burst_raddr   = (state_q == ST_APP_RD) ? idx_q : sidx;
		burst_we      = state_q == ST_CAL_WR;
		burst_waddr   = sidx;
		if (!bvalid_q[sidx]) begin
			burst_wdata = {rd_q, rd_q};
		end else begin
			burst_wdata = {(rd_q > bmax) ? rd_q : bmax, (rd_q < bmin) ? rd_q : bmin};
		end
	end

	always_ff @(posedge clk) begin
		if (stor_we) begin
			stor_mem[stor_waddr] <= stor_wdata;
		end
		if (stor_re) begin
			stor_rd_q <= stor_mem[stor_raddr];
		end
		if (burst_we) begin
			burst_mem[burst_waddr] <= burst_wdata;
		end
		if (burst_re) begin
			burst_rd_q <= burst_mem[burst_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd8;
			fs_q  <= 12'd1023;
			cen_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COUNT:      cnt_q <= cfg_data[3:0];
				REG_FULL_SCALE: fs_q  <= cfg_data;
				REG_CAL_ENABLE: cen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= 1'b0;
			seen_q   <= 1'b0;
			wsum_q   <= '0;
			vsum_q   <= '0;
			prev_q   <= '0;
			bvalid_q <= '0;
			idx_q    <= '0;
			step_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_CLR: begin
					if (idx_q == IDX_LAST) begin
						idx_q <= '0;
						if (act_q == ACT_CAL) begin
							cal_q <= 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CAL_RD: begin
					if (first_q) begin
						bvalid_q <= '0;
					end
				end
				ST_CAL_WR: bvalid_q[sidx] <= 1'b1;
				ST_APP_WR: idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
				ST_POS_RD: begin
					if (first_q) begin
						wsum_q <= '0;
						vsum_q <= '0;
						seen_q <= 1'b0;
					end
				end
				ST_POS_MUL: step_q <= DIV_STEP_W'(DIV_W - 1);
				ST_DIV_SC:  step_q <= step_q - 1'b1;
				ST_POS_ACC: begin
					if (val_q > VAL_W'(SEEN_LIMIT)) begin
						seen_q <= 1'b1;
					end
				end
				ST_POS_SUM: begin
					if (val_q > VAL_W'(WEIGHT_LIMIT)) begin
						wsum_q <= wsum_add[DIV_W] ? '1 : wsum_add[DIV_W-1:0];
						vsum_q <= vsum_add[DIV_W] ? '1 : vsum_add[DIV_W-1:0];
					end
				end
				ST_POS_END: step_q <= DIV_STEP_W'(DIV_W - 1);
				ST_DIV_POS: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						prev_q <= 13'(pos_cap);
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= s_axis_tuser[1:0];
			first_q  <= s_axis_tuser[2];
			last_q   <= s_axis_tlast;
			sensor_q <= s_axis_tdata[2:0];
			rd_q     <= RB'(s_axis_tdata[14:3]);
		end
		unique case (state_q)
			ST_POS_SC: begin
				diff_q <= rd_q - smin;
				span_q <= span_c;
				if (!in_use) begin
					val_q <= '0;
				end else if (!cal_q) begin
					val_q <= VAL_W'(rd_q);
				end else begin
					val_q <= '0;
				end
			end
			ST_POS_MUL: begin
				rem_q <= '0;
				quo_q <= DIV_W'(NUM_W'(diff_q) * NUM_W'(SCALE_FULL));
				dvs_q <= DIV_W'(span_q);
			end
			ST_DIV_SC, ST_DIV_POS: begin
				rem_q <= div_ge ? DIV_W'(div_tmp - {1'b0, dvs_q}) : div_tmp[DIV_W-1:0];
				quo_q <= div_qn;
				if ((state_q == ST_DIV_SC) && (step_q == '0)) begin
					val_q <= (div_qn > DIV_W'(SCALE_FULL)) ? VAL_W'(SCALE_FULL) : VAL_W'(div_qn);
				end
				if ((state_q == ST_DIV_POS) && (step_q == '0)) begin
					pos_q <= 13'(pos_cap);
				end
			end
			ST_POS_ACC: prod_q <= DIV_W'(val_q * (VAL_W + WGT_W)'(wgt));
			ST_POS_END: begin
				pos_q <= 13'(pos_edge);
				rem_q <= '0;
				quo_q <= wsum_q;
				dvs_q <= vsum_q;
			end
			default: ;
		endcase
		if (emit) begin
			out_scaled_q <= 12'(val_q);
			out_pos_q    <= last_q ? pos_q : 13'd0;
			out_last_q   <= last_q;
			out_seen_q   <= last_q && seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_pos_q, out_scaled_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_seen_q;

endmodule

`default_nettype wire

/* hdl/lpe_checker.sv */
// Port-level checks of the line position estimator and their binding.
`default_nettype none

module lpe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready
);

	a_seen_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("line seen flag without end of sweep");

	a_pos_zero_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[24:12] == 13'd0)
		else $error("position nonzero inside sweep");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind line_position_estimator_core lpe_checker u_lpe_checker (.*);

`default_nettype wire
